// ----- design/mht_pkg.sv -----
// shared types and constants of the magnetometer heading block
// no dependencies; used by every module in this folder
package mht_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_HWEIGHT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_VWEIGHT = 8'd1;

  // field widths
  localparam int unsigned MagW    = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned HeadW   = 12;

  // datapath widths
  localparam int unsigned ProdW  = 2 * MagW;     // one weighted axis term
  localparam int unsigned ProjW  = ProdW + 1;    // sum of two terms
  localparam int unsigned MagnW  = ProdW;        // magnitude of a projection
  localparam int unsigned VecShift = 22;
  localparam int unsigned XyW    = 56;           // cordic x and y, signed
  localparam int unsigned ZW     = 29;           // cordic angle, signed
  localparam int unsigned PhiW   = 30;
  localparam int unsigned ThetaW = 31;
  localparam int unsigned AngFrac = 20;
  localparam int unsigned Iters  = 24;

  // angles in units of 2^-20 degree
  localparam logic signed [PhiW-1:0]   DEG90  = PhiW'(90) <<< AngFrac;
  localparam logic signed [ThetaW-1:0] DEG180 = ThetaW'(180) <<< AngFrac;
  localparam logic signed [ThetaW-1:0] DEG360 = ThetaW'(360) <<< AngFrac;

  localparam logic [HeadW-1:0] HEAD_MAX  = 12'd3599;
  localparam logic [HeadW-1:0] HEAD_NULL = 12'd900;

  // atan(2^-i) in degrees, rounded to 2^-20 degree
  localparam logic signed [ZW-1:0] ATAN_TAB [Iters] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
    29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
    29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
    29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
    29'sd917,      29'sd458,      29'sd229,      29'sd115,
    29'sd57,       29'sd29,       29'sd14,       29'sd7
  };

  // per-item flags that ride along the cell chain
  typedef struct packed {
    logic valid;
    logic both_zero;  // p and q both zero
    logic aw_zero;    // p is zero
    logic au_zero;    // q is zero
    logic swap;       // |q| < |p|, chain measures from the other axis
    logic q_neg;
    logic p_neg;
  } side_t;

endpackage

// ----- design/mht_prep.sv -----
// front end: weighted projections, magnitudes and octant reduction
// depends on mht_pkg
module mht_prep (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  in_valid_i,
  input  logic signed [mht_pkg::MagW-1:0]       mag_x_i,
  input  logic signed [mht_pkg::MagW-1:0]       mag_y_i,
  input  logic signed [mht_pkg::MagW-1:0]       mag_z_i,
  input  logic signed [mht_pkg::WeightW-1:0]    hweight_i,
  input  logic signed [mht_pkg::WeightW-1:0]    vweight_i,
  output logic signed [mht_pkg::XyW-1:0]        x_o,
  output logic signed [mht_pkg::XyW-1:0]        y_o,
  output mht_pkg::side_t                        side_o
);

  // stage a: three products
  logic                                 va_q;
  logic signed [mht_pkg::ProdW-1:0]     hx_q, hy_q, vz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hx_q <= hweight_i * mag_x_i;
      hy_q <= hweight_i * mag_y_i;
      vz_q <= vweight_i * mag_z_i;
    end
  end

  // stage b: projections
  logic                                 vb_q;
  logic signed [mht_pkg::ProjW-1:0]     p_q, q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= mht_pkg::ProjW'(hx_q) + mht_pkg::ProjW'(vz_q);
      q_q <= mht_pkg::ProjW'(hy_q) + mht_pkg::ProjW'(vz_q);
    end
  end

  // stage c: magnitudes, octant and scaled start vector
  logic signed [mht_pkg::ProjW-1:0] p_abs, q_abs;
  logic        [mht_pkg::MagnW-1:0] aw, au, big, small_m;
  mht_pkg::side_t                   side_d, side_q;
  logic signed [mht_pkg::XyW-1:0]   x_q, y_q;

  always_comb begin
    p_abs = p_q[mht_pkg::ProjW-1] ? -p_q : p_q;
    q_abs = q_q[mht_pkg::ProjW-1] ? -q_q : q_q;
    aw    = p_abs[mht_pkg::MagnW-1:0];
    au    = q_abs[mht_pkg::MagnW-1:0];
    side_d.valid     = vb_q;
    side_d.aw_zero   = (aw == '0);
    side_d.au_zero   = (au == '0);
    side_d.both_zero = side_d.aw_zero && side_d.au_zero;
    side_d.swap      = (au < aw);
    side_d.q_neg     = q_q[mht_pkg::ProjW-1];
    side_d.p_neg     = p_q[mht_pkg::ProjW-1];
    big     = side_d.swap ? aw : au;
    small_m = side_d.swap ? au : aw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= {2'b00, big, {mht_pkg::VecShift{1'b0}}};
      y_q <= {2'b00, small_m, {mht_pkg::VecShift{1'b0}}};
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign side_o = side_q;

endmodule

// ----- design/mht_cordic_cell.sv -----
// one vectoring rotation of the cordic chain, registered
// depends on mht_pkg for widths and the arctangent table
module mht_cordic_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic signed [mht_pkg::XyW-1:0]  x_i,
  input  logic signed [mht_pkg::XyW-1:0]  y_i,
  input  logic signed [mht_pkg::ZW-1:0]   z_i,
  input  mht_pkg::side_t                  side_i,
  output logic signed [mht_pkg::XyW-1:0]  x_o,
  output logic signed [mht_pkg::XyW-1:0]  y_o,
  output logic signed [mht_pkg::ZW-1:0]   z_o,
  output mht_pkg::side_t                  side_o
);

  logic signed [mht_pkg::XyW-1:0] dx, dy, x_d, y_d;
  logic signed [mht_pkg::ZW-1:0]  z_d;
  logic signed [mht_pkg::XyW-1:0] x_q, y_q;
  logic signed [mht_pkg::ZW-1:0]  z_q;
  mht_pkg::side_t                 side_q;

  // rotate toward the x axis, floor shifts
  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (!y_i[mht_pkg::XyW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + mht_pkg::ATAN_TAB[SHIFT];
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - mht_pkg::ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

// ----- design/mht_finish.sv -----
// back end: quadrant rebuild, then tenths of a degree with clamping
// depends on mht_pkg
module mht_finish (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [mht_pkg::ZW-1:0]     z_i,
  input  mht_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic [mht_pkg::HeadW-1:0]         heading_o
);

  localparam int unsigned ProdW = mht_pkg::ThetaW + 3;
  localparam int unsigned TenW  = ProdW - mht_pkg::AngFrac;

  logic signed [mht_pkg::PhiW-1:0]   phi;
  logic signed [mht_pkg::ThetaW-1:0] theta_d, theta_q;
  logic                              valid_q, null_q;

  // angle within the quadrant, then full turn
  always_comb begin
    if (side_i.aw_zero) begin
      phi = '0;
    end else if (side_i.au_zero) begin
      phi = mht_pkg::DEG90;
    end else if (side_i.swap) begin
      phi = mht_pkg::DEG90 - mht_pkg::PhiW'(z_i);
    end else begin
      phi = mht_pkg::PhiW'(z_i);
    end
    if (!side_i.q_neg && !side_i.p_neg) begin
      theta_d = mht_pkg::ThetaW'(phi);
    end else if (side_i.q_neg && !side_i.p_neg) begin
      theta_d = mht_pkg::DEG180 - mht_pkg::ThetaW'(phi);
    end else if (side_i.q_neg) begin
      theta_d = mht_pkg::DEG180 + mht_pkg::ThetaW'(phi);
    end else begin
      theta_d = mht_pkg::DEG360 - mht_pkg::ThetaW'(phi);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      theta_q <= theta_d;
      null_q  <= side_i.both_zero;
    end
  end

  // times ten, drop the fraction, clamp both ends
  logic [mht_pkg::ThetaW-1:0] theta_pos;
  logic [ProdW-1:0]           prod;
  logic [TenW-1:0]            tenths;

  always_comb begin
    theta_pos = theta_q[mht_pkg::ThetaW-1] ? '0 : theta_q;
    prod      = {theta_pos, 3'b000} + {2'b00, theta_pos, 1'b0};
    tenths    = prod[ProdW-1:mht_pkg::AngFrac];
    if (null_q) begin
      heading_o = mht_pkg::HEAD_NULL;
    end else if (tenths > TenW'(mht_pkg::HEAD_MAX)) begin
      heading_o = mht_pkg::HEAD_MAX;
    end else begin
      heading_o = tenths[mht_pkg::HeadW-1:0];
    end
  end

  assign valid_o = valid_q;

endmodule

// ----- design/magnetometer_heading_tenths.sv -----
// compass heading in tenths of a degree from one magnetometer sample
// path from input accept to m_axis_tvalid: 3 front-end stages, 24 cordic cells,
// quadrant stage, output register
// throughput: one item per cycle; the chain holds only while the output
// register is full and not taken
// reset: weights return to 8939 and 31525, all valid flags clear
module magnetometer_heading_tenths (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // mag_x, mag_y, mag_z
  // item out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // heading_tenths, 4 pad bits
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mht_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mht_pkg::WeightW-1:0]    cfg_data_i
);

  // weight registers
  logic signed [mht_pkg::WeightW-1:0] hweight_q, vweight_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hweight_q <= 16'sd8939;
      vweight_q <= 16'sd31525;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mht_pkg::REG_HWEIGHT: hweight_q <= cfg_data_i;
        mht_pkg::REG_VWEIGHT: vweight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // chain advances unless a finished item cannot move out
  logic                            fin_valid;
  logic [mht_pkg::HeadW-1:0]       fin_heading;
  logic                            out_valid_q, out_valid_d;
  logic [mht_pkg::HeadW-1:0]       heading_q;
  logic                            adv;

  assign adv           = !(fin_valid && out_valid_q && !m_axis_tready);
  assign s_axis_tready = adv;

  // front end
  logic signed [mht_pkg::XyW-1:0] x_s [mht_pkg::Iters+1];
  logic signed [mht_pkg::XyW-1:0] y_s [mht_pkg::Iters+1];
  logic signed [mht_pkg::ZW-1:0]  z_s [mht_pkg::Iters+1];
  mht_pkg::side_t                 side_s [mht_pkg::Iters+1];

  mht_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .in_valid_i (s_axis_tvalid),
    .mag_x_i    (s_axis_tdata[15:0]),
    .mag_y_i    (s_axis_tdata[31:16]),
    .mag_z_i    (s_axis_tdata[47:32]),
    .hweight_i  (hweight_q),
    .vweight_i  (vweight_q),
    .x_o        (x_s[0]),
    .y_o        (y_s[0]),
    .side_o     (side_s[0])
  );

  assign z_s[0] = '0;

  // cordic chain, one cell per iteration
  for (genvar gi = 0; gi < mht_pkg::Iters; gi++) begin : g_cell
    mht_cordic_cell #(
      .SHIFT (gi)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .x_i    (x_s[gi]),
      .y_i    (y_s[gi]),
      .z_i    (z_s[gi]),
      .side_i (side_s[gi]),
      .x_o    (x_s[gi+1]),
      .y_o    (y_s[gi+1]),
      .z_o    (z_s[gi+1]),
      .side_o (side_s[gi+1])
    );
  end

  // back end
  mht_finish u_finish (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .z_i       (z_s[mht_pkg::Iters]),
    .side_i    (side_s[mht_pkg::Iters]),
    .valid_o   (fin_valid),
    .heading_o (fin_heading)
  );

  // output register
  always_comb begin
    if (fin_valid && adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid && adv) begin
      heading_q <= fin_heading;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, heading_q};

`ifndef ASSERT_OFF
  // heading stays inside one turn
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:0] <= mht_pkg::HEAD_MAX))
    else $error("heading out of range");

  // cordic x starts non-negative and is still non-negative at the chain end
  a_x_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_s[mht_pkg::Iters].valid |-> !x_s[mht_pkg::Iters][mht_pkg::XyW-1])
    else $error("cordic x went negative");

  // a held result at the chain end is not dropped
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid && !adv) |=> (fin_valid && out_valid_q))
    else $error("stalled item lost at chain end");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for magnetometer_heading_tenths: directed table, then random samples
// depends on design/mht_pkg.sv for register indexes and field widths
module tb_top;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_SET = 100;
  localparam int NUM_SETS     = 12;
  localparam int NO_WANT      = -1;

  // register indexes the block must ignore
  localparam logic [mht_pkg::CfgIdxW-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [mht_pkg::CfgIdxW-1:0] REG_UNUSED_HI = 8'hff;

  // predictor angle format: 2^-20 degree units
  localparam int     ANG_BITS     = 20;
  localparam int     PRESCALE     = 22;
  localparam int     CORDIC_STEPS = 24;
  localparam longint QUARTER      = longint'(90) << ANG_BITS;
  localparam longint HALF_TURN    = longint'(180) << ANG_BITS;
  localparam longint FULL_TURN    = longint'(360) << ANG_BITS;
  localparam longint ARCTAN_UNITS [0:23] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    int                 want;
  } sample_row_t;

  // directed rows under the reset weights; want is typed in where obvious
  localparam int NUM_DIRECTED = 22;
  localparam sample_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
    '{16'sd0,      16'sd0,      16'sd0,      900},      // both projections zero
    '{16'sd1000,   16'sd0,      16'sd0,      900},      // q zero, p positive
    '{16'sd32767,  16'sd0,      16'sd0,      900},
    '{-16'sd32768, 16'sd0,      16'sd0,      2700},     // q zero, p negative
    '{-16'sd1,     16'sd0,      16'sd0,      2700},
    '{16'sd0,      16'sd32767,  16'sd0,      0},        // p zero, q positive
    '{16'sd0,      16'sd1,      16'sd0,      0},
    '{16'sd0,      -16'sd32768, 16'sd0,      1800},     // p zero, q negative
    '{16'sd0,      -16'sd1,     16'sd0,      1800},
    '{16'sd0,      16'sd0,      16'sd1000,   NO_WANT},  // equal magnitudes
    '{16'sd0,      16'sd0,      -16'sd32768, NO_WANT},
    '{16'sd32767,  16'sd32767,  16'sd32767,  NO_WANT},
    '{-16'sd32768, -16'sd32768, -16'sd32768, NO_WANT},
    '{16'sd32767,  -16'sd32768, 16'sd0,      NO_WANT},
    '{-16'sd32768, 16'sd32767,  -16'sd32768, NO_WANT},
    '{-16'sd32768, 16'sd1,      16'sd0,      NO_WANT},  // either side of 270
    '{-16'sd32768, -16'sd1,     16'sd0,      NO_WANT},
    '{16'sd1,      -16'sd32768, 16'sd0,      NO_WANT},
    '{16'sd1,      16'sd32767,  16'sd0,      NO_WANT},  // just past zero
    '{-16'sd1,     -16'sd1,     16'sd0,      NO_WANT},
    '{16'sd12345,  -16'sd23456, 16'sd777,    NO_WANT},
    '{-16'sd21846, 16'sd10923,  16'sd5461,   NO_WANT}
  };

  // corner samples sent after every weight change
  localparam int NUM_CORNERS = 10;
  localparam sample_row_t CORNERS [0:NUM_CORNERS-1] = '{
    '{16'sd0,      16'sd0,      16'sd0,      NO_WANT},
    '{16'sd32767,  16'sd32767,  16'sd32767,  NO_WANT},
    '{-16'sd32768, -16'sd32768, -16'sd32768, NO_WANT},
    '{16'sd32767,  -16'sd32768, 16'sd1,      NO_WANT},
    '{16'sd0,      16'sd32767,  16'sd1,      NO_WANT},  // tiny p, huge q
    '{16'sd0,      -16'sd32768, 16'sd1,      NO_WANT},
    '{16'sd1,      16'sd0,      16'sd32767,  NO_WANT},
    '{-16'sd32768, 16'sd1,      16'sd0,      NO_WANT},
    '{16'sd0,      16'sd0,      -16'sd32768, NO_WANT},
    '{-16'sd1,     16'sd1,      -16'sd1,     NO_WANT}
  };

  // fixed weight settings {horizontal, vertical}, extremes first
  localparam int NUM_FIXED_SETS = 9;
  localparam logic [31:0] WEIGHT_SETS [0:NUM_FIXED_SETS-1] = '{
    {16'h7fff, 16'h7fff}, {16'h8000, 16'h8000}, {16'h0000, 16'h0000},
    {16'h0000, 16'h7fff}, {16'h7fff, 16'h0000}, {16'h8000, 16'h7fff},
    {16'h7fff, 16'h0001}, {16'h0001, 16'h8000}, {16'hffff, 16'hffff}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [47:0]                 s_axis_tdata = '0;   // mag_x, mag_y, mag_z
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [15:0]                 m_axis_tdata;        // heading_tenths, 4 pad bits
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [mht_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [mht_pkg::WeightW-1:0] cfg_data_i = '0;

  logic signed [15:0] weight_h;
  logic signed [15:0] weight_v;
  int                 heading_q [$];
  int                 idle_pct = 0;
  int                 out_stall = 0;
  int                 cycle_cnt = 0;
  int                 n_sent = 0;
  int                 n_checked = 0;
  int                 n_fail = 0;

  magnetometer_heading_tenths DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL magnetometer_heading_tenths");
      $finish;
    end
  end

  // vectoring cordic on a first-octant vector, big >= small > 0
  function automatic longint octant_angle(input longint big, input longint small_side);
    longint cx, cy, cz, dx, dy;
    int     i;
    cx = big <<< PRESCALE;
    cy = small_side <<< PRESCALE;
    cz = 0;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + ARCTAN_UNITS[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - ARCTAN_UNITS[i];
      end
    end
    return cz;
  endfunction

  // heading in tenths for one sample under the current weights
  function automatic int heading_of(input logic signed [15:0] mx, my, mz);
    longint p, q, mag_p, mag_q, phi, theta, tenths;
    p = longint'(weight_h) * longint'(mx) + longint'(weight_v) * longint'(mz);
    q = longint'(weight_h) * longint'(my) + longint'(weight_v) * longint'(mz);
    mag_p = (p < 0) ? -p : p;
    mag_q = (q < 0) ? -q : q;
    if (mag_p == 0 && mag_q == 0) return 900;
    if (mag_p == 0) phi = 0;
    else if (mag_q == 0) phi = QUARTER;
    else if (mag_q >= mag_p) phi = octant_angle(mag_q, mag_p);
    else phi = QUARTER - octant_angle(mag_p, mag_q);
    // rebuild the full angle from the signs
    if (q >= 0 && p >= 0) theta = phi;
    else if (q < 0 && p >= 0) theta = HALF_TURN - phi;
    else if (q < 0) theta = HALF_TURN + phi;
    else theta = FULL_TURN - phi;
    if (theta < 0) theta = 0;
    tenths = (theta * 10) >>> ANG_BITS;
    if (tenths > 3599) tenths = 3599;
    return int'(tenths);
  endfunction

  // an axis value at or near the ends of the range
  function automatic int edge_val();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      4: return 32767;
      5: return 32767 - int'($urandom_range(0, 3));
      default: return -32768 + int'($urandom_range(0, 3));
    endcase
  endfunction

  // random sample: mostly full range, plus small, edge, cancelling and on-axis samples
  task automatic pick_random_sample(output logic signed [15:0] mx, my, mz);
    int mode;
    mode = $urandom_range(0, 9);
    mx = 16'($urandom);
    my = 16'($urandom);
    mz = 16'($urandom);
    case (mode)
      5: begin
        mx = 16'(int'($urandom_range(0, 16)) - 8);
        my = 16'(int'($urandom_range(0, 16)) - 8);
        mz = 16'(int'($urandom_range(0, 16)) - 8);
      end
      6, 7: begin
        mx = 16'(edge_val());
        my = 16'(edge_val());
        mz = 16'(edge_val());
      end
      8: begin
        // cancels the z term when both weights match
        mz = 16'(int'($urandom_range(0, 65534)) - 32767);
        mx = -mz;
        if ($urandom_range(0, 1) != 0) my = -mz;
      end
      9: begin
        case ($urandom_range(0, 2))
          0: begin my = '0; mz = '0; end
          1: begin mx = '0; mz = '0; end
          default: begin mx = '0; my = '0; end
        endcase
      end
      default: ;
    endcase
  endtask

  // offer one sample and record its expected heading on accept
  task automatic send_sample(input logic signed [15:0] mx, my, mz, input int want);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mz, my, mx};
    do @(posedge clk_i); while (!s_axis_tready);
    heading_q.push_back((want != NO_WANT) ? want : heading_of(mx, my, mz));
    n_sent++;
  endtask

  // stop offering and wait for every heading to come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one register write, block idle
  task automatic write_reg(input logic [mht_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == mht_pkg::REG_HWEIGHT) weight_h = val;
    else if (idx == mht_pkg::REG_VWEIGHT) weight_v = val;
    @(posedge clk_i);
  endtask

  // output side stalls in random bursts
  always @(posedge clk_i) begin
    if (out_stall != 0) begin
      out_stall     <= out_stall - 1;
      m_axis_tready <= (out_stall == 1);
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 3) begin
      out_stall     <= $urandom_range(1, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each accepted heading with the oldest expectation
  always @(posedge clk_i) begin : check_heading
    int want_h;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (heading_q.size() == 0) begin
        $error("heading_tenths: expected none, actual %0d", m_axis_tdata);
        n_fail++;
      end else begin
        want_h = heading_q.pop_front();
        n_checked++;
        if (m_axis_tdata !== 16'(want_h)) begin
          $error("heading_tenths: expected %0d, actual %0d", want_h, m_axis_tdata);
          n_fail++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic signed [15:0] rx, ry, rz;
    logic [15:0]        set_h, set_v;
    int                 k, set_idx;
    weight_h = 16'sd8939;
    weight_v = 16'sd31525;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed table under the reset weights, idling on
    idle_pct = 25;
    for (k = 0; k < NUM_DIRECTED; k++)
      send_sample(DIRECTED[k].mx, DIRECTED[k].my, DIRECTED[k].mz, DIRECTED[k].want);
    drain();

    // weight settings, each with corners then random samples
    for (set_idx = 0; set_idx < NUM_SETS; set_idx++) begin
      if (set_idx < NUM_FIXED_SETS) begin
        {set_h, set_v} = WEIGHT_SETS[set_idx];
      end else if (set_idx < NUM_SETS - 1) begin
        set_h = 16'($urandom);
        set_v = 16'($urandom);
      end else begin
        set_h = 16'd8939;
        set_v = 16'd31525;
      end
      write_reg(mht_pkg::REG_HWEIGHT, set_h);
      write_reg(mht_pkg::REG_VWEIGHT, set_v);
      // writes to indexes past the last register must change nothing
      if (set_idx % 4 == 1) write_reg(REG_UNUSED_LO, 16'($urandom));
      if (set_idx % 4 == 3) write_reg(REG_UNUSED_HI, 16'($urandom));
      // no idling in every third setting and in the last one
      idle_pct = (set_idx == NUM_SETS - 1 || set_idx % 3 == 2) ? 0 : 25;
      for (k = 0; k < NUM_CORNERS; k++)
        send_sample(CORNERS[k].mx, CORNERS[k].my, CORNERS[k].mz, NO_WANT);
      for (k = 0; k < RANDOM_PER_SET; k++) begin
        pick_random_sample(rx, ry, rz);
        send_sample(rx, ry, rz, NO_WANT);
      end
      drain();
    end

    $display("covered %0d directed rows and %0d weight settings with random stalls",
             NUM_DIRECTED, NUM_SETS);
    $display("sent %0d samples, checked %0d headings, %0d mismatches",
             n_sent, n_checked, n_fail);
    if (n_fail == 0) begin
      $display("PASS magnetometer_heading_tenths");
    end else begin
      $display("FAIL magnetometer_heading_tenths");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mht_pkg.sv
design/mht_prep.sv
design/mht_cordic_cell.sv
design/mht_finish.sv
design/magnetometer_heading_tenths.sv
tb/tb_top.sv
